### rtl/core/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Token kinds, scanner modes, result record and keyword tables.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int OUT_POS_W = 20;

    localparam logic [6:0] K_ID          = 7'd41;
    localparam logic [6:0] K_INT         = 7'd42;
    localparam logic [6:0] K_FLOAT       = 7'd43;
    localparam logic [6:0] K_COLON_COLON = 7'd44;
    localparam logic [6:0] K_COLON_EQ    = 7'd45;
    localparam logic [6:0] K_COLON       = 7'd46;
    localparam logic [6:0] K_DDOT_EQ     = 7'd47;
    localparam logic [6:0] K_DDOT        = 7'd48;
    localparam logic [6:0] K_DOT         = 7'd49;
    localparam logic [6:0] K_LPAREN      = 7'd50;
    localparam logic [6:0] K_RPAREN      = 7'd51;
    localparam logic [6:0] K_LBRACE      = 7'd52;
    localparam logic [6:0] K_RBRACE      = 7'd53;
    localparam logic [6:0] K_LBRACKET    = 7'd54;
    localparam logic [6:0] K_RBRACKET    = 7'd55;
    localparam logic [6:0] K_COMMA       = 7'd56;
    localparam logic [6:0] K_SEMI        = 7'd57;
    localparam logic [6:0] K_FAT_ARROW   = 7'd58;
    localparam logic [6:0] K_EQ_EQ       = 7'd59;
    localparam logic [6:0] K_EQ          = 7'd60;
    localparam logic [6:0] K_BANG_EQ     = 7'd61;
    localparam logic [6:0] K_BANG        = 7'd62;
    localparam logic [6:0] K_LESS_EQ     = 7'd63;
    localparam logic [6:0] K_LESS        = 7'd64;
    localparam logic [6:0] K_GREATER_EQ  = 7'd65;
    localparam logic [6:0] K_GREATER     = 7'd66;
    localparam logic [6:0] K_AND_AND     = 7'd67;
    localparam logic [6:0] K_AND         = 7'd68;
    localparam logic [6:0] K_OR_OR       = 7'd69;
    localparam logic [6:0] K_OR          = 7'd70;
    localparam logic [6:0] K_PLUS_EQ     = 7'd71;
    localparam logic [6:0] K_PLUS        = 7'd72;
    localparam logic [6:0] K_ARROW       = 7'd73;
    localparam logic [6:0] K_MINUS_EQ    = 7'd74;
    localparam logic [6:0] K_MINUS       = 7'd75;
    localparam logic [6:0] K_STAR_EQ     = 7'd76;
    localparam logic [6:0] K_STAR        = 7'd77;
    localparam logic [6:0] K_SLASH_EQ    = 7'd78;
    localparam logic [6:0] K_SLASH       = 7'd79;
    localparam logic [6:0] K_PERCENT     = 7'd80;
    localparam logic [6:0] K_NEWLINE     = 7'd81;
    localparam logic [6:0] K_END         = 7'd82;
    localparam logic [6:0] K_ERROR       = 7'd83;
    localparam logic [6:0] K_UNSUPPORTED = 7'd84;
    localparam logic [6:0] K_NONE        = 7'd0;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_EXP_SIGN,
        MODE_EXP,
        MODE_OP,
        MODE_DOTDOT,
        MODE_COMMENT
    } scan_mode_t;

    typedef struct packed {
        logic [6:0]           kind;
        logic [OUT_POS_W-1:0] offset;
        logic [OUT_POS_W-1:0] length;
        logic [OUT_POS_W-1:0] line;
        logic [OUT_POS_W-1:0] column;
        logic [63:0]          value;
        logic                 last;
    } result_t;

    localparam int NUM_KW  = 41;
    localparam int NUM_RSV = 7;

    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("module"), 64'("pub"), 64'("fn"), 64'("var"), 64'("if"), 64'("else"),
        64'("loop"), 64'("for"), 64'("break"), 64'("continue"), 64'("true"),
        64'("false"), 64'("type"), 64'("struct"), 64'("mut"), 64'("immut"),
        64'("enum"), 64'("pact"), 64'("match"), 64'("return"), 64'("while"),
        64'("defer"), 64'("bool"), 64'("i8"), 64'("i16"), 64'("i32"), 64'("i64"),
        64'("i128"), 64'("u8"), 64'("u16"), 64'("u32"), 64'("u64"), 64'("u128"),
        64'("isize"), 64'("usize"), 64'("f32"), 64'("f64"), 64'("char"),
        64'("str"), 64'("unit"), 64'("never")
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd6, 4'd3, 4'd2, 4'd3, 4'd2, 4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd4,
        4'd5, 4'd4, 4'd6, 4'd3, 4'd5, 4'd4, 4'd4, 4'd5, 4'd6, 4'd5,
        4'd5, 4'd4, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd2, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5
    };

    localparam logic [63:0] RSV_TEXT [NUM_RSV] = '{
        64'("async"), 64'("await"), 64'("comptime"), 64'("macro"), 64'("spawn"),
        64'("use"), 64'("where")
    };

    localparam logic [3:0] RSV_LEN [NUM_RSV] = '{
        4'd5, 4'd5, 4'd8, 4'd5, 4'd5, 4'd3, 4'd5
    };

    function automatic logic [6:0] word_kind(input logic [63:0] word, input logic [3:0] len);
        logic [6:0] k;
        logic       hit;
        k   = K_ID;
        hit = 1'b0;
        for (int i = NUM_RSV - 1; i >= 0; i--) begin
            if (len == RSV_LEN[i] && word == RSV_TEXT[i]) begin
                k = K_ERROR;
            end
        end
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            if (len == KW_LEN[i] && word == KW_TEXT[i]) begin
                k   = 7'(i);
                hit = 1'b1;
            end
        end
        return hit ? k : k;
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] h);
        logic [6:0] k;
        case (h)
            "=":     k = K_EQ;
            "!":     k = K_BANG;
            "<":     k = K_LESS;
            ">":     k = K_GREATER;
            "&":     k = K_AND;
            "|":     k = K_OR;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            ":":     k = K_COLON;
            default: k = K_DOT;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
        logic [6:0] k;
        k = K_NONE;
        if (h == "=" && c == ">") begin
            k = K_FAT_ARROW;
        end else if (h == "-" && c == ">") begin
            k = K_ARROW;
        end else if (h == ":" && c == ":") begin
            k = K_COLON_COLON;
        end else if (h == "&" && c == "&") begin
            k = K_AND_AND;
        end else if (h == "|" && c == "|") begin
            k = K_OR_OR;
        end else if (c == "=") begin
            case (h)
                "=":     k = K_EQ_EQ;
                "!":     k = K_BANG_EQ;
                "<":     k = K_LESS_EQ;
                ">":     k = K_GREATER_EQ;
                "+":     k = K_PLUS_EQ;
                "-":     k = K_MINUS_EQ;
                "*":     k = K_STAR_EQ;
                "/":     k = K_SLASH_EQ;
                ":":     k = K_COLON_EQ;
                default: k = K_NONE;
            endcase
        end
        return k;
    endfunction

endpackage

### rtl/core/sct_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_scan
// Scanner state and per-byte next-state logic; yields up to two results.
// ----------------------------------------------------------------------------
module sct_scan #(
    parameter int POSITION_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        ch,
    output logic [1:0]        emit_cnt,
    output sct_pkg::result_t  emit0,
    output sct_pkg::result_t  emit1
);
    import sct_pkg::*;

    localparam int PB = POSITION_BITS;

    scan_mode_t       mode_reg, mode_next;
    logic [63:0]      word_reg, word_next;
    logic [3:0]       wlen_reg, wlen_next;
    logic [63:0]      acc_reg, acc_next;
    logic             sat_reg, sat_next;
    logic             flt_reg, flt_next;
    logic [7:0]       held_reg, held_next;
    logic [PB-1:0]    off_reg, off_next;
    logic [PB-1:0]    line_reg, line_next;
    logic [PB-1:0]    col_reg, col_next;
    logic [PB-1:0]    toff_reg, toff_next;
    logic [PB-1:0]    tline_reg, tline_next;
    logic [PB-1:0]    tcol_reg, tcol_next;
    logic [PB-1:0]    doff_reg, doff_next;
    logic [PB-1:0]    dline_reg, dline_next;
    logic [PB-1:0]    dcol_reg, dcol_next;
    logic [PB-1:0]    lex_reg, lex_next;
    logic             pdot_reg, pdot_next;
    logic             fin_reg, fin_next;

    function automatic logic [PB-1:0] sinc(input logic [PB-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_POS_W-1:0] to_out(input logic [PB-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_POS_W-1:0];
    endfunction

    logic          em_a, em_b, restart, is_dig, is_alp;
    logic [6:0]    ka, kb, pk;
    logic [PB-1:0] la, lb, lexf;
    logic [63:0]   va;
    logic [67:0]   prod;
    result_t       ra, rb;

    always_comb
    begin
        mode_next  = mode_reg;
        word_next  = word_reg;
        wlen_next  = wlen_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        flt_next   = flt_reg;
        held_next  = held_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        toff_next  = toff_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        doff_next  = doff_reg;
        dline_next = dline_reg;
        dcol_next  = dcol_reg;
        lex_next   = lex_reg;
        pdot_next  = pdot_reg;
        fin_next   = fin_reg;
        em_a       = 1'b0;
        em_b       = 1'b0;
        restart    = 1'b0;
        ka         = K_NONE;
        kb         = K_NONE;
        la         = '0;
        lb         = '0;
        va         = '0;
        pk         = K_NONE;
        lexf       = sinc(lex_reg);
        is_dig     = ch inside {["0":"9"]};
        is_alp     = ch inside {["a":"z"], ["A":"Z"], "_"};
        prod       = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {60'd0, ch - 8'h30};

        if (take && !fin_reg)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alp || is_dig)
                    begin
                        if (wlen_reg < 4'd8)
                        begin
                            word_next = {word_reg[55:0], ch};
                        end
                        if (wlen_reg < 4'd9)
                        begin
                            wlen_next = wlen_reg + 4'd1;
                        end
                        lex_next = lexf;
                    end
                    else
                    begin
                        em_a    = 1'b1;
                        ka      = word_kind(word_reg, wlen_reg);
                        la      = lex_reg;
                        restart = 1'b1;
                    end
                end
                MODE_INT:
                begin
                    if (is_dig)
                    begin
                        if (!sat_reg)
                        begin
                            if (prod[67:64] != 4'd0)
                            begin
                                sat_next = 1'b1;
                                acc_next = '1;
                            end
                            else
                            begin
                                acc_next = prod[63:0];
                            end
                        end
                        lex_next = lexf;
                    end
                    else if (ch == "_")
                    begin
                        lex_next = lexf;
                    end
                    else if (ch == "." && !pdot_reg)
                    begin
                        doff_next  = off_reg;
                        dline_next = line_reg;
                        dcol_next  = col_reg;
                        mode_next  = MODE_DOT;
                    end
                    else if (ch == "e" || ch == "E")
                    begin
                        flt_next  = 1'b1;
                        lex_next  = lexf;
                        mode_next = MODE_EXP_SIGN;
                    end
                    else
                    begin
                        em_a    = 1'b1;
                        ka      = flt_reg ? K_FLOAT : K_INT;
                        va      = flt_reg ? 64'd0 : acc_reg;
                        la      = lex_reg;
                        restart = 1'b1;
                    end
                end
                MODE_DOT:
                begin
                    if (ch == ".")
                    begin
                        em_a       = 1'b1;
                        ka         = flt_reg ? K_FLOAT : K_INT;
                        va         = flt_reg ? 64'd0 : acc_reg;
                        la         = lex_reg;
                        toff_next  = doff_reg;
                        tline_next = dline_reg;
                        tcol_next  = dcol_reg;
                        mode_next  = MODE_DOTDOT;
                    end
                    else
                    begin
                        flt_next  = 1'b1;
                        mode_next = MODE_FRAC;
                        lex_next  = lexf;
                        if (is_dig || ch == "_")
                        begin
                            lex_next = sinc(lexf);
                        end
                        else if (ch == "e" || ch == "E")
                        begin
                            lex_next  = sinc(lexf);
                            mode_next = MODE_EXP_SIGN;
                        end
                        else
                        begin
                            em_a    = 1'b1;
                            ka      = K_FLOAT;
                            la      = lexf;
                            restart = 1'b1;
                        end
                    end
                end
                MODE_FRAC:
                begin
                    if (is_dig || ch == "_")
                    begin
                        lex_next = lexf;
                    end
                    else if (ch == "e" || ch == "E")
                    begin
                        lex_next  = lexf;
                        mode_next = MODE_EXP_SIGN;
                    end
                    else
                    begin
                        em_a    = 1'b1;
                        ka      = flt_reg ? K_FLOAT : K_INT;
                        va      = flt_reg ? 64'd0 : acc_reg;
                        la      = lex_reg;
                        restart = 1'b1;
                    end
                end
                MODE_EXP_SIGN:
                begin
                    if (ch == "+" || ch == "-" || is_dig)
                    begin
                        lex_next  = lexf;
                        mode_next = MODE_EXP;
                    end
                    else
                    begin
                        em_a    = 1'b1;
                        ka      = flt_reg ? K_FLOAT : K_INT;
                        va      = flt_reg ? 64'd0 : acc_reg;
                        la      = lex_reg;
                        restart = 1'b1;
                    end
                end
                MODE_EXP:
                begin
                    if (is_dig)
                    begin
                        lex_next = lexf;
                    end
                    else
                    begin
                        em_a    = 1'b1;
                        ka      = flt_reg ? K_FLOAT : K_INT;
                        va      = flt_reg ? 64'd0 : acc_reg;
                        la      = lex_reg;
                        restart = 1'b1;
                    end
                end
                MODE_OP:
                begin
                    pk = pair_kind(held_reg, ch);
                    if (held_reg == "/" && ch == "/")
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else if (held_reg == "." && ch == ".")
                    begin
                        mode_next = MODE_DOTDOT;
                    end
                    else if (pk != K_NONE)
                    begin
                        em_a      = 1'b1;
                        ka        = pk;
                        la        = PB'(2);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        em_a    = 1'b1;
                        ka      = single_kind(held_reg);
                        la      = PB'(1);
                        restart = 1'b1;
                    end
                end
                MODE_DOTDOT:
                begin
                    if (ch == "=")
                    begin
                        em_a      = 1'b1;
                        ka        = K_DDOT_EQ;
                        la        = PB'(3);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        em_a    = 1'b1;
                        ka      = K_DDOT;
                        la      = PB'(2);
                        restart = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (ch == 8'h0a || ch == 8'h00)
                    begin
                        restart = 1'b1;
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase

            if (em_a)
            begin
                pdot_next = (ka == K_DOT);
            end

            if (restart)
            begin
                mode_next = MODE_IDLE;
                if (!(ch == 8'h20 || ch == 8'h09 || ch == 8'h0d))
                begin
                    toff_next  = off_reg;
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    lb         = PB'(1);
                    if (ch == 8'h0a)
                    begin
                        em_b = 1'b1;
                        kb   = K_NEWLINE;
                    end
                    else if (ch == 8'h00)
                    begin
                        em_b     = 1'b1;
                        kb       = K_END;
                        lb       = '0;
                        fin_next = 1'b1;
                    end
                    else if (is_dig)
                    begin
                        mode_next = MODE_INT;
                        lex_next  = PB'(1);
                        acc_next  = {60'd0, 4'(ch - 8'h30)};
                        sat_next  = 1'b0;
                        flt_next  = 1'b0;
                    end
                    else if (is_alp)
                    begin
                        mode_next = MODE_IDENT;
                        word_next = {56'd0, ch};
                        wlen_next = 4'd1;
                        lex_next  = PB'(1);
                    end
                    else
                    begin
                        case (ch)
                            8'h22, 8'h27: begin em_b = 1'b1; kb = K_UNSUPPORTED; end
                            "(": begin em_b = 1'b1; kb = K_LPAREN; end
                            ")": begin em_b = 1'b1; kb = K_RPAREN; end
                            "{": begin em_b = 1'b1; kb = K_LBRACE; end
                            "}": begin em_b = 1'b1; kb = K_RBRACE; end
                            "[": begin em_b = 1'b1; kb = K_LBRACKET; end
                            "]": begin em_b = 1'b1; kb = K_RBRACKET; end
                            ",": begin em_b = 1'b1; kb = K_COMMA; end
                            ";": begin em_b = 1'b1; kb = K_SEMI; end
                            "%": begin em_b = 1'b1; kb = K_PERCENT; end
                            "=", "!", "<", ">", "&", "|", "+", "-", "*", "/", ":", ".":
                            begin
                                mode_next = MODE_OP;
                                held_next = ch;
                            end
                            default: begin em_b = 1'b1; kb = K_ERROR; end
                        endcase
                    end
                    if (em_b)
                    begin
                        pdot_next = 1'b0;
                    end
                end
            end

            if (ch == 8'h0a)
            begin
                line_next = sinc(line_reg);
                col_next  = PB'(1);
            end
            else
            begin
                col_next = sinc(col_reg);
            end
            off_next = sinc(off_reg);
        end
    end

    always_comb
    begin
        ra.kind   = ka;
        ra.offset = to_out(toff_reg);
        ra.length = to_out(la);
        ra.line   = to_out(tline_reg);
        ra.column = to_out(tcol_reg);
        ra.value  = va;
        ra.last   = !em_b;
        rb.kind   = kb;
        rb.offset = to_out(off_reg);
        rb.length = to_out(lb);
        rb.line   = to_out(line_reg);
        rb.column = to_out(col_reg);
        rb.value  = '0;
        rb.last   = 1'b1;
        emit0     = em_a ? ra : rb;
        emit1     = rb;
        emit_cnt  = 2'(em_a) + 2'(em_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            word_reg  <= '0;
            wlen_reg  <= '0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            flt_reg   <= 1'b0;
            held_reg  <= '0;
            off_reg   <= '0;
            line_reg  <= PB'(1);
            col_reg   <= PB'(1);
            toff_reg  <= '0;
            tline_reg <= '0;
            tcol_reg  <= '0;
            doff_reg  <= '0;
            dline_reg <= '0;
            dcol_reg  <= '0;
            lex_reg   <= '0;
            pdot_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            word_reg  <= word_next;
            wlen_reg  <= wlen_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
            flt_reg   <= flt_next;
            held_reg  <= held_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            toff_reg  <= toff_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            doff_reg  <= doff_next;
            dline_reg <= dline_next;
            dcol_reg  <= dcol_next;
            lex_reg   <= lex_next;
            pdot_reg  <= pdot_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

### rtl/core/source_code_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_code_tokenizer_core
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Source channel: src_valid/src_ready with one byte ch per transfer; byte 0
// ends the source and every later byte is taken and dropped until reset.
// Token channel: tok_valid/tok_ready with kind, start offset, length, line,
// column, integer value and last (high on the final token of a source byte).
// A byte is scanned in the cycle it is taken; its tokens enter a four-entry
// result queue, and the first appears on the token channel in the next cycle
// if the queue was empty. One byte per cycle is taken while the queue has
// room for two tokens; two tokens of one byte pop one at a time, so the queue
// port sets the sustained rate at one token per cycle if tok_ready is high.
// Reset clears the scanner to idle at line 1, column 1 and empties the
// queue. When the receiver stalls, the queue fills and src_ready drops.
// ----------------------------------------------------------------------------
module source_code_tokenizer_core #(
    parameter int POSITION_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_ready,
    input  logic [7:0]                    ch,
    output logic                          tok_valid,
    input  logic                          tok_ready,
    output logic [6:0]                    token_kind,
    output logic [sct_pkg::OUT_POS_W-1:0] start_offset,
    output logic [sct_pkg::OUT_POS_W-1:0] token_length,
    output logic [sct_pkg::OUT_POS_W-1:0] line,
    output logic [sct_pkg::OUT_POS_W-1:0] column,
    output logic [63:0]                   int_value,
    output logic                          last
);
    import sct_pkg::*;

    logic       take, pop;
    logic [1:0] emit_cnt;
    result_t    emit0, emit1, head;
    result_t    queue_reg [4];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    sct_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .ch       (ch),
        .emit_cnt (emit_cnt),
        .emit0    (emit0),
        .emit1    (emit1)
    );

    assign src_ready = (cnt_reg < 3'd3);
    assign take      = src_valid && src_ready;
    assign tok_valid = (cnt_reg != 3'd0);
    assign pop       = tok_valid && tok_ready;
    assign head      = queue_reg[rd_reg];

    assign token_kind   = head.kind;
    assign start_offset = head.offset;
    assign token_length = head.length;
    assign line         = head.line;
    assign column       = head.column;
    assign int_value    = head.value;
    assign last         = head.last;

    always_comb
    begin
        wr_next  = wr_reg + emit_cnt;
        rd_next  = rd_reg + 2'(pop);
        cnt_next = cnt_reg + 3'(emit_cnt) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (emit_cnt != 2'd0)
        begin
            queue_reg[wr_reg] <= emit0;
        end
        if (emit_cnt == 2'd2)
        begin
            queue_reg[wr_reg + 2'd1] <= emit1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
